>>> rtl/core/qmpr_pkg.sv
// Shared types, constants and helper functions for the QR mask pattern rewriter.
`timescale 1ns / 1ps
`default_nettype none

package qmpr_pkg;

  // Store geometry
  localparam int MAX_WIDTH   = 32;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Configuration reset value
  localparam logic [7:0] CODE_WIDTH_RESET = 8'd25;

  // Module byte flag marking a non-data module
  localparam int NONDATA_BIT = 7;

  // Level L, pattern 0 format bits; bit i is format bit index i
  localparam logic [14:0] FMT_L0_BITS = 15'b001000111110111;

  // Format mask over mask field columns 2, 3, 4 (bit 2 belongs to column 2)
  localparam logic [2:0] FMT_MASK_XOR = 3'b101;

  // Row holding the mask field of the first format copy
  localparam logic [7:0] FMT_ROW_LINE = 8'd8;
  localparam logic [7:0] FMT_MASK_COL_LO = 8'd2;
  localparam logic [7:0] FMT_MASK_COL_HI = 8'd4;

  // First format copy positions per bit index
  localparam logic [7:0] FMT_ROW [0:14] = '{
    8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8,
    8'd7, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0
  };
  localparam logic [7:0] FMT_COL [0:14] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd8,
    8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8
  };

  // Reciprocal multiplier for division by 3 of an 8-bit value: (x * 171) >> 9
  localparam logic [7:0] DIV3_MUL   = 8'd171;
  localparam int         DIV3_SHIFT = 9;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // take a new transaction into the input registers
    logic calc;     // evaluate address, range and remask flags
    logic access;   // drive the store: write or read address
    logic capture;  // build and present the read result
  } qmpr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_read;
  } qmpr_sts_t;

  // Residue mod 3 of a 10-bit value; 4 is 1 mod 3, so sum base-4 digits
  function automatic logic [1:0] mod3(input logic [9:0] x);
    logic [3:0] s;
    logic [2:0] t;
    s = '0;
    for (int k = 0; k < 5; k++) begin
      s = s + 4'(x[2*k +: 2]);
    end
    t = 3'(s[3:2]) + 3'(s[1:0]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // Product of two residues mod 3
  function automatic logic [1:0] mul_mod3(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] res;
    if (a == 2'd0 || b == 2'd0) begin
      res = 2'd0;
    end else if (a == b) begin
      res = 2'd1;
    end else begin
      res = 2'd2;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qmpr_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module qmpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/qmpr_ctrl.sv
// Controller state machine sequencing one transaction at a time.
`timescale 1ns / 1ps
`default_nettype none

module qmpr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire qmpr_pkg::qmpr_sts_t sts,
  output qmpr_pkg::qmpr_cmd_t      cmd,
  output logic                     busy
);

  import qmpr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CALC   = 2'd1;
  localparam logic [1:0] S_ACCESS = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Advance through calc, access and, for reads, capture
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        state_next = S_ACCESS;
      end
      S_ACCESS: begin
        state_next = sts.is_read ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands
  assign cmd.load    = (state == S_IDLE) && start;
  assign cmd.calc    = (state == S_CALC);
  assign cmd.access  = (state == S_ACCESS);
  assign cmd.capture = (state == S_READ);
  assign busy        = (state != S_IDLE);

  // An accepted transaction always moves on to the calc step
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CALC))
    else $error("accepted transaction did not enter calc");

  // A write finishes right after its store access
  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCESS && !sts.is_read) |=> (state == S_IDLE))
    else $error("write did not return to idle after access");

  // A read passes through capture exactly after its access
  a_read_capture: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCESS && sts.is_read) |=> (state == S_READ))
    else $error("read skipped the capture step");

endmodule

`default_nettype wire

>>> rtl/core/qmpr_datapath.sv
// Datapath: input registers, address and remask evaluation, module store, result.
`timescale 1ns / 1ps
`default_nettype none

module qmpr_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qmpr_pkg::qmpr_cmd_t cmd,
  output qmpr_pkg::qmpr_sts_t      sts,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                operation,
  input  wire logic [7:0]          row,
  input  wire logic [7:0]          col,
  input  wire logic [7:0]          module_byte,
  output logic [7:0]               remasked_byte,
  output logic                     done
);

  import qmpr_pkg::*;

  // Configuration and held mask number
  logic [7:0] code_width;
  logic [2:0] old_mask;

  // Transaction registers
  logic       op_q;
  logic [7:0] row_q;
  logic [7:0] col_q;
  logic [7:0] byte_q;

  // Calc step results
  logic              valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic              fmt_hit_q;
  logic              fmt_bit_q;
  logic              flip_q;

  // Calc step logic
  logic [15:0]       row_prod;
  logic [16:0]       lin;
  logic              in_range;
  logic [1:0]        rm3;
  logic [1:0]        cm3;
  logic [1:0]        sm3;
  logic [1:0]        pm3;
  logic [15:0]       c_mul3;
  logic              cdiv3_par;
  logic              p_odd;
  logic              sum_odd;
  logic              inv_base;
  logic              inv_old;
  logic              fmt_hit;
  logic              fmt_bit;

  // Store access and result
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [7:0]        res_byte;
  logic              mask_upd;
  logic [1:0]        mask_idx;

  // Hold the code width register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_width <= CODE_WIDTH_RESET;
    end else if (cfg_we) begin
      code_width <= cfg_wdata;
    end
  end

  // Take a new transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      row_q  <= row;
      col_q  <= col;
      byte_q <= module_byte;
    end
  end

  assign sts.is_read = op_q;

  // Linear address and range check
  assign row_prod = row_q * code_width;
  assign lin      = {1'b0, row_prod} + {9'b0, col_q};
  assign in_range = (row_q < code_width) && (col_q < code_width) &&
                    (lin < 17'(STORE_DEPTH));

  // Residues and parities used by the mask patterns
  assign rm3       = mod3({2'b00, row_q});
  assign cm3       = mod3({2'b00, col_q});
  assign sm3       = mod3(10'({1'b0, row_q} + {1'b0, col_q}));
  assign pm3       = mul_mod3(rm3, cm3);
  assign c_mul3    = col_q * DIV3_MUL;
  assign cdiv3_par = c_mul3[DIV3_SHIFT];
  assign p_odd     = row_q[0] & col_q[0];
  assign sum_odd   = row_q[0] ^ col_q[0];
  assign inv_base  = ~sum_odd;

  // Evaluate the held mask pattern at this module
  always_comb begin
    case (old_mask)
      3'd0:    inv_old = ~sum_odd;
      3'd1:    inv_old = ~row_q[0];
      3'd2:    inv_old = (cm3 == 2'd0);
      3'd3:    inv_old = (sm3 == 2'd0);
      3'd4:    inv_old = ~(row_q[1] ^ cdiv3_par);
      3'd5:    inv_old = ~p_odd && (pm3 == 2'd0);
      3'd6:    inv_old = ~(p_odd ^ pm3[0]);
      default: inv_old = ~(sum_odd ^ pm3[0]);
    endcase
  end

  // Match both format copies; later matches overwrite earlier ones
  always_comb begin
    fmt_hit = 1'b0;
    fmt_bit = 1'b0;
    for (int i = 0; i < 15; i++) begin
      if (row_q == FMT_ROW[i] && col_q == FMT_COL[i]) begin
        fmt_hit = 1'b1;
        fmt_bit = FMT_L0_BITS[i];
      end
      if (i < 7) begin
        if ((({1'b0, row_q} + 9'(i + 1)) == {1'b0, code_width}) &&
            (col_q == FMT_ROW_LINE)) begin
          fmt_hit = 1'b1;
          fmt_bit = FMT_L0_BITS[i];
        end
      end else begin
        if ((row_q == FMT_ROW_LINE) &&
            (({1'b0, col_q} + 9'(15 - i)) == {1'b0, code_width})) begin
          fmt_hit = 1'b1;
          fmt_bit = FMT_L0_BITS[i];
        end
      end
    end
  end

  // Register the calc step
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      valid_q   <= in_range;
      addr_q    <= lin[ADDR_W-1:0];
      fmt_hit_q <= fmt_hit;
      fmt_bit_q <= fmt_bit;
      flip_q    <= inv_old ^ inv_base;
    end
  end

  // Store access
  assign ram_we = cmd.access && !op_q && valid_q;

  qmpr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr_q),
    .wdata (byte_q),
    .rdata (ram_rdata)
  );

  // Update the held mask number on a write to the mask field
  assign mask_upd = ram_we && (row_q == FMT_ROW_LINE) &&
                    (col_q >= FMT_MASK_COL_LO) && (col_q <= FMT_MASK_COL_HI);
  assign mask_idx = 2'(3'd4 - col_q[2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      old_mask <= '0;
    end else if (mask_upd) begin
      old_mask[mask_idx] <= byte_q[0] ^ FMT_MASK_XOR[mask_idx];
    end
  end

  // Rewrite the dark bit of the read byte; an out-of-range access reads as zero
  always_comb begin
    res_byte = ram_rdata;
    if (fmt_hit_q) begin
      res_byte[0] = fmt_bit_q;
    end else if (!ram_rdata[NONDATA_BIT] && flip_q) begin
      res_byte[0] = ~ram_rdata[0];
    end
    if (!valid_q) begin
      res_byte = '0;
    end
  end

  // Register the result, which holds until the next capture, and raise done for one cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      remasked_byte <= res_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.capture;
    end
  end

  // A result strobe follows a capture step
  a_done_after_capture: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.capture))
    else $error("result strobe without capture");

  // The store is only written by a write transaction in its access step
  a_write_gate: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (cmd.access && !op_q))
    else $error("store written outside a write access");

  // The held mask number only moves after a store write
  a_mask_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(old_mask)) |-> $past(ram_we))
    else $error("mask number changed without a store write");

endmodule

`default_nettype wire

>>> rtl/core/qr_mask_pattern_rewriter_top.sv
// Top level of the QR mask pattern rewriter: controller plus datapath.
//
//   Channel   | Ports                                      | Handshake
//   ----------+--------------------------------------------+-------------------------
//   command   | operation, row, col, module_byte           | start high, busy low
//   result    | remasked_byte                              | done high for one cycle
//   config    | cfg_wdata                                  | cfg_we high
//
// A write passes through the calc and access steps; a read adds a capture step for the
// store's registered read port, and remasked_byte and done are registered from it.
// One transaction is in flight at a time; busy is high from acceptance to the end.
// rst clears the controller, the held mask number and code_width (to 25); the
// store holds no reset value. done cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module qr_mask_pattern_rewriter_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       operation,
  input  wire logic [7:0] row,
  input  wire logic [7:0] col,
  input  wire logic [7:0] module_byte,
  output logic [7:0]      remasked_byte,
  output logic            done,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  import qmpr_pkg::*;

  qmpr_cmd_t cmd;
  qmpr_sts_t sts;

  // Sequence each transaction
  qmpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Address, store and remask logic
  qmpr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .operation     (operation),
    .row           (row),
    .col           (col),
    .module_byte   (module_byte),
    .remasked_byte (remasked_byte),
    .done          (done)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the QR mask pattern rewriter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_ENTRIES = 32 * 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 220;

  // Level L, mask pattern 0 format bits, bit index 0 leftmost
  localparam bit [0:14] FORMAT_L_MASK0 = 15'b111011111000100;

  typedef enum bit {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } access_op_t;

  // One directed transaction; lit_valid marks a hand-typed expected byte
  typedef struct packed {
    access_op_t op;
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] b;
    bit         lit_valid;
    logic [7:0] lit;
  } probe_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       operation;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] module_byte;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  wire        busy;
  wire        done;
  wire  [7:0] remasked_byte;

  // Shadow copy of the block state
  logic [7:0]  shadow_store [STORE_ENTRIES];
  bit          shadow_written [STORE_ENTRIES];
  logic [2:0]  shadow_mask = 3'd0;
  int unsigned shadow_width = 25;

  logic [7:0] pending_remasked [$];
  int         fail_count = 0;
  int         idle_pct = 38;
  int         stall_cycles = 0;

  qr_mask_pattern_rewriter_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .row          (row),
    .col          (col),
    .module_byte  (module_byte),
    .remasked_byte(remasked_byte),
    .done         (done),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Does the given data mask pattern invert module (r, c)
  function automatic bit pattern_flips(input logic [2:0] pattern, input int unsigned r, c);
    int unsigned p;
    p = r * c;
    case (pattern)
      3'd0: return (r + c) % 2 == 0;
      3'd1: return r % 2 == 0;
      3'd2: return c % 3 == 0;
      3'd3: return (r + c) % 3 == 0;
      3'd4: return (r / 2 + c / 3) % 2 == 0;
      3'd5: return (p % 2) + (p % 3) == 0;
      3'd6: return ((p % 2) + (p % 3)) % 2 == 0;
      default: return (((r + c) % 2) + (p % 3)) % 2 == 0;
    endcase
  endfunction

  // Position of format bit i in the first copy (second = 0) or the second copy
  function automatic void format_position(input int i, input bit second, input int w,
                                          output int r, output int c);
    if (!second) begin
      // row 8 left of the finder gap skips column 6, column 8 skips row 6
      if (i < 8) begin
        r = 8;
        c = (i < 6) ? i : i + 1;
      end else begin
        r = (i == 8) ? 7 : 14 - i;
        c = 8;
      end
    end else if (i < 7) begin
      r = w - 1 - i;
      c = 8;
    end else begin
      r = 8;
      c = w - 15 + i;
    end
  endfunction

  // Format bit forced at (r, c), if any; later bit index and second copy win
  function automatic bit format_bit_at(input int r, c, w, output bit fbit);
    bit hit;
    int pr;
    int pc;
    hit = 1'b0;
    fbit = 1'b0;
    for (int i = 0; i < 15; i++) begin
      for (int k = 0; k < 2; k++) begin
        format_position(i, k[0], w, pr, pc);
        if (pr == r && pc == c) begin
          hit = 1'b1;
          fbit = FORMAT_L_MASK0[i];
        end
      end
    end
    return hit;
  endfunction

  function automatic bit in_store(input logic [7:0] r, c);
    return r < shadow_width && c < shadow_width && r * shadow_width + c < STORE_ENTRIES;
  endfunction

  function automatic bit readable(input logic [7:0] r, c);
    return in_store(r, c) && shadow_written[r * shadow_width + c];
  endfunction

  // Apply one accepted transaction to the shadow state; reads yield a byte
  task automatic apply_access(input access_op_t op, input logic [7:0] r, c, b,
                              output bit yields, output logic [7:0] result);
    int unsigned addr;
    bit fbit;
    logic [7:0] v;
    addr = r * shadow_width + c;
    yields = (op == OP_READ);
    result = 8'h00;
    if (op == OP_WRITE) begin
      if (in_store(r, c)) begin
        shadow_store[addr] = b;
        shadow_written[addr] = 1'b1;
        // mask field: format mask is 1, 0, 1 over columns 2, 3, 4
        if (r == 8'd8 && c >= 8'd2 && c <= 8'd4) begin
          shadow_mask[4 - c] = b[0] ^ (c != 8'd3);
        end
      end
    end else if (in_store(r, c)) begin
      v = shadow_store[addr];
      if (format_bit_at(int'(r), int'(c), int'(shadow_width), fbit)) begin
        v[0] = fbit;
      end else if (!v[7] && pattern_flips(shadow_mask, r, c) != pattern_flips(3'd0, r, c)) begin
        v[0] = ~v[0];
      end
      result = v;
    end
  endtask

  // Drive one transaction from a falling edge and hold it until accepted
  task automatic send(input access_op_t op, input logic [7:0] r, c, b,
                      input bit lit_valid, input logic [7:0] lit);
    bit yields;
    logic [7:0] predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    row <= r;
    col <= c;
    module_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_access(op, r, c, b, yields, predicted);
    if (yields) begin
      pending_remasked.push_back(lit_valid ? lit : predicted);
    end
    @(negedge clk);
  endtask

  task automatic log_mismatch(input string what, input logic [7:0] want, got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns %s: expected %02h, got %02h", $time, what, want, got);
    end
  endtask

  // Random module position that lands inside the store at the current width
  task automatic pick_in_range(output logic [7:0] r, output logic [7:0] c);
    int unsigned rmax;
    int unsigned rr;
    int unsigned cc;
    rmax = (STORE_ENTRIES - 1) / shadow_width;
    if (rmax > shadow_width - 1) begin
      rmax = shadow_width - 1;
    end
    do begin
      rr = $urandom_range(rmax);
      cc = $urandom_range(shadow_width - 1);
    end while (rr * shadow_width + cc >= STORE_ENTRIES);
    r = 8'(rr);
    c = 8'(cc);
  endtask

  // Compare each result against the oldest outstanding read
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_remasked.size() == 0) begin
        log_mismatch("remasked_byte with no read outstanding", 8'h00, remasked_byte);
      end else begin
        if (pending_remasked[0] !== remasked_byte) begin
          log_mismatch("remasked_byte", pending_remasked[0], remasked_byte);
        end
        void'(pending_remasked.pop_front());
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    probe_t     directed_probes [25];
    int         phase_widths [8];
    access_op_t op;
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] b;
    int         fr;
    int         fc;
    int         pick;
    bit         found;

    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    row = 8'd0;
    col = 8'd0;
    module_byte = 8'd0;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;

    // Directed checks at the reset width of 25
    directed_probes = '{
      '{OP_READ,  8'd25,  8'd0,  8'h00, 1'b1, 8'h00},  // row out of range
      '{OP_READ,  8'd176, 8'd176, 8'h00, 1'b1, 8'h00}, // both at field maximum
      '{OP_READ,  8'd3,   8'd25, 8'h00, 1'b1, 8'h00},  // column out of range
      '{OP_WRITE, 8'd0,   8'd0,  8'hFF, 1'b0, 8'h00},
      '{OP_WRITE, 8'd24,  8'd24, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, 8'd8,   8'd2,  8'h01, 1'b0, 8'h00},  // mask field, old mask 011
      '{OP_WRITE, 8'd8,   8'd3,  8'h01, 1'b0, 8'h00},
      '{OP_WRITE, 8'd8,   8'd4,  8'h00, 1'b0, 8'h00},
      '{OP_READ,  8'd0,   8'd0,  8'h00, 1'b1, 8'hFF},  // non-data, kept
      '{OP_READ,  8'd24,  8'd24, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  8'd8,   8'd2,  8'h00, 1'b1, 8'h01},  // first format copy
      '{OP_WRITE, 8'd8,   8'd5,  8'h7E, 1'b0, 8'h00},
      '{OP_READ,  8'd8,   8'd5,  8'h00, 1'b1, 8'h7F},  // format over data module
      '{OP_WRITE, 8'd24,  8'd8,  8'h80, 1'b0, 8'h00},
      '{OP_READ,  8'd24,  8'd8,  8'h00, 1'b1, 8'h81},  // second copy, bottom
      '{OP_WRITE, 8'd8,   8'd24, 8'hFE, 1'b0, 8'h00},
      '{OP_READ,  8'd8,   8'd24, 8'h00, 1'b1, 8'hFE},  // second copy, right
      '{OP_WRITE, 8'd8,   8'd6,  8'h01, 1'b0, 8'h00},
      '{OP_READ,  8'd8,   8'd6,  8'h00, 1'b0, 8'h00},
      '{OP_WRITE, 8'd25,  8'd3,  8'hAA, 1'b0, 8'h00},  // dropped write
      '{OP_WRITE, 8'd12,  8'd13, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  8'd12,  8'd13, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, 8'd8,   8'd4,  8'h01, 1'b0, 8'h00},  // old mask 010
      '{OP_READ,  8'd12,  8'd13, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  8'd24,  8'd24, 8'h00, 1'b0, 8'h00}
    };
    phase_widths = '{21, 177, 31, 33, 101, 23, 67, 25};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_probes[i]) begin
      send(directed_probes[i].op, directed_probes[i].r, directed_probes[i].c,
           directed_probes[i].b, directed_probes[i].lit_valid, directed_probes[i].lit);
    end

    for (int ph = 0; ph < 8; ph++) begin
      // Drain, let a trailing write finish, then change the code width
      start <= 1'b0;
      while (pending_remasked.size() != 0 || busy) @(negedge clk);
      repeat (8) @(negedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= 8'(phase_widths[ph]);
      shadow_width = phase_widths[ph];
      @(negedge clk);
      cfg_we <= 1'b0;
      // one phase runs back to back with no sender gaps
      idle_pct = (ph == 2) ? 0 : 38;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        b = 8'($urandom);
        op = OP_WRITE;
        if (pick < 8) begin
          // noise anywhere in the field range; never read an unwritten entry
          op = access_op_t'($urandom_range(1));
          r = 8'($urandom_range(176));
          c = 8'($urandom_range(176));
          if (op == OP_READ && in_store(r, c) && !readable(r, c)) begin
            op = OP_WRITE;
          end
        end else if (pick < 20) begin
          r = 8'd8;
          c = 8'($urandom_range(4, 2));
        end else if (pick < 40) begin
          format_position($urandom_range(14), 1'($urandom_range(1)), shadow_width, fr, fc);
          r = 8'(fr);
          c = 8'(fc);
        end else if (pick < 60) begin
          pick_in_range(r, c);
        end else begin
          op = OP_READ;
          found = 1'b0;
          for (int k = 0; k < 12 && !found; k++) begin
            if ($urandom_range(99) < 35) begin
              format_position($urandom_range(14), 1'($urandom_range(1)), shadow_width,
                              fr, fc);
              r = 8'(fr);
              c = 8'(fc);
            end else begin
              pick_in_range(r, c);
            end
            found = readable(r, c);
          end
          if (!found) begin
            op = OP_WRITE;
          end
        end
        send(op, r, c, b, 1'b0, 8'h00);
      end
    end

    // Wait out the last results, then report
    start <= 1'b0;
    while (pending_remasked.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending_remasked.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
